/* rtl/owbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared widths, register codes, reset values and types of the 1-Wire master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int CFG_W     = 10;
   localparam int CFG_NUM   = 8;
   localparam int CFG_IDX_W = 3;
   localparam int BYTE_W    = 8;
   localparam int TIME_W    = 11;
   localparam int BIT_IDX_W = 3;

   localparam logic [TIME_W-1:0] TIME_MAX            = 11'd2047;
   localparam logic [TIME_W-1:0] PRESENCE_TIMEOUT_US = 11'd1023;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_RESET = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_RESET_LOW     = 3'd0,
      CFG_PRESENCE_HOLD = 3'd1,
      CFG_WR1_LOW       = 3'd2,
      CFG_WR1_HIGH      = 3'd3,
      CFG_WR0_LOW       = 3'd4,
      CFG_WR0_HIGH      = 3'd5,
      CFG_RD_LOW        = 3'd6,
      CFG_RD_RECOVERY   = 3'd7
   } cfg_index_type;

   typedef logic [CFG_W-1:0] cfg_word_type;

   typedef struct packed {
      cfg_word_type reset_low;
      cfg_word_type presence_hold;
      cfg_word_type wr1_low;
      cfg_word_type wr1_high;
      cfg_word_type wr0_low;
      cfg_word_type wr0_high;
      cfg_word_type rd_low;
      cfg_word_type rd_recovery;
   } cfg_bank_type;

   localparam cfg_bank_type CFG_RESET_VALUES = '{
      reset_low:     10'd500,
      presence_hold: 10'd300,
      wr1_low:       10'd8,
      wr1_high:      10'd80,
      wr0_low:       10'd90,
      wr0_high:      10'd5,
      rd_low:        10'd2,
      rd_recovery:   10'd70
   };

   typedef struct packed {
      logic              drive_low;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] rx_byte;
      logic              no_device;
   } step_result_type;

endpackage
`default_nettype wire

/* rtl/one_wire_bus_master_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// 1-Wire bus master stepped by one-microsecond tick transfers.
//
// Each req_ transfer is one microsecond: req_type selects tick only, reset
// with presence detect, write byte or read byte (both LSB first), with the
// byte to send and the sampled line level. Every req_ transfer yields exactly
// one rsp_ transfer with the drive level, busy and done flags, the last read
// byte and the missing-device flag for that microsecond.
// Requests arriving while a command runs are ignored.
// A transfer passes an input register, then the timing state machine
// evaluated between that register and the result register. Throughput is one
// transfer per cycle while rsp_stall is low.
// When rsp_stall is high the result register holds and the input register
// fills; req_stall then rises until the result is taken.
// The csr_ port writes the eight 10-bit timing registers; write them only
// while the block is idle.
// Synchronous reset restores the timing defaults, empties both registers and
// returns the state machine to idle with a cleared read byte and flags.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [1:0]                       req_type,
   input  wire  [owbm_pkg::BYTE_W-1:0]      req_tx_byte,
   input  wire                              req_line_level,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_drive_low,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [owbm_pkg::BYTE_W-1:0]      rsp_rx_byte,
   output logic                             rsp_no_device,
   input  wire                              csr_wr_en,
   input  wire  [owbm_pkg::CFG_IDX_W-1:0]   csr_index,
   input  wire  [owbm_pkg::CFG_W-1:0]       csr_wr_data
);
   import owbm_pkg::*;

   cfg_bank_type      cfg;
   step_result_type   step_res;
   step_result_type   res_ff;

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_type_ff;
   logic [BYTE_W-1:0] in_tx_ff;
   logic              in_line_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic              req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   owbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   owbm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .req_code   (in_type_ff),
      .tx_byte    (in_tx_ff),
      .line_level (in_line_ff),
      .cfg        (cfg),
      .result     (step_res)
   );

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_type;
         in_tx_ff   <= req_tx_byte;
         in_line_ff <= req_line_level;
      end
      if (advance) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = res_ff.drive_low;
   assign rsp_busy_res  = res_ff.busy;
   assign rsp_done_res  = res_ff.done;
   assign rsp_rx_byte   = res_ff.rx_byte;
   assign rsp_no_device = res_ff.no_device;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done reported outside a command");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("bus driven low outside a command");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("request stalled with empty input register");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced transfer lost before result register");

endmodule
`default_nettype wire

/* rtl/owbm_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_csr
// Timing register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire  [owbm_pkg::CFG_IDX_W-1:0]     csr_index,
   input  wire  [owbm_pkg::CFG_W-1:0]         csr_wr_data,
   output owbm_pkg::cfg_bank_type             cfg
);
   import owbm_pkg::*;

   cfg_bank_type cfg_ff;
   cfg_bank_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (cfg_index_type'(csr_index))
            CFG_RESET_LOW:     cfg_in.reset_low     = csr_wr_data;
            CFG_PRESENCE_HOLD: cfg_in.presence_hold = csr_wr_data;
            CFG_WR1_LOW:       cfg_in.wr1_low       = csr_wr_data;
            CFG_WR1_HIGH:      cfg_in.wr1_high      = csr_wr_data;
            CFG_WR0_LOW:       cfg_in.wr0_low       = csr_wr_data;
            CFG_WR0_HIGH:      cfg_in.wr0_high      = csr_wr_data;
            CFG_RD_LOW:        cfg_in.rd_low        = csr_wr_data;
            CFG_RD_RECOVERY:   cfg_in.rd_recovery   = csr_wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET_VALUES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/owbm_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_engine
// Bus timing state machine; advances one microsecond per enabled cycle.
// ----------------------------------------------------------------------------
module owbm_engine (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              step_en,
   input  wire  [1:0]                       req_code,
   input  wire  [owbm_pkg::BYTE_W-1:0]      tx_byte,
   input  wire                              line_level,
   input  owbm_pkg::cfg_bank_type           cfg,
   output owbm_pkg::step_result_type        result
);
   import owbm_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_REL   = 4'd2,
      PH_PRES_LOW  = 4'd3,
      PH_PRES_HIGH = 4'd4,
      PH_PRES_HOLD = 4'd5,
      PH_WR_LOW    = 4'd6,
      PH_WR_HIGH   = 4'd7,
      PH_RD_LOW    = 4'd8,
      PH_RD_REL    = 4'd9,
      PH_RD_REC    = 4'd10
   } phase_type;

   phase_type              phase_ff,  phase_in;
   logic [TIME_W-1:0]      time_ff,   time_in;
   logic [BIT_IDX_W-1:0]   bit_idx_ff, bit_idx_in;
   logic [BYTE_W-1:0]      shift_ff,  shift_in;
   logic [BYTE_W-1:0]      rx_ff,     rx_in;
   logic                   absent_ff, absent_in;
   logic                   drive, busy, done;
   logic [TIME_W-1:0]      lim;

   function automatic logic [TIME_W-1:0] at_least_one(input cfg_word_type v);
      return (v == '0) ? TIME_W'(1) : TIME_W'(v);
   endfunction

   function automatic logic [TIME_W-1:0] widen(input cfg_word_type v);
      return TIME_W'(v);
   endfunction

   always_comb begin
      phase_in   = phase_ff;
      time_in    = time_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      rx_in      = rx_ff;
      absent_in  = absent_ff;
      drive      = 1'b0;
      busy       = 1'b0;
      done       = 1'b0;
      lim        = '0;

      if (phase_in == PH_IDLE && req_code != REQ_TICK) begin
         time_in    = '0;
         bit_idx_in = '0;
         case (req_code_type'(req_code))
            REQ_RESET: begin
               absent_in = 1'b0;
               phase_in  = PH_RST_LOW;
            end
            REQ_WRITE: begin
               shift_in = tx_byte;
               phase_in = PH_WR_LOW;
            end
            default: begin
               shift_in = '0;
               phase_in = PH_RD_LOW;
            end
         endcase
      end

      if (phase_in != PH_IDLE) begin
         busy = 1'b1;
         if (time_in != TIME_MAX) time_in = time_in + TIME_W'(1);
         case (phase_in)
            PH_RST_LOW: begin
               drive = 1'b1;
               if (time_in >= at_least_one(cfg.reset_low)) begin
                  phase_in = PH_RST_REL;
                  time_in  = '0;
               end
            end
            PH_RST_REL: begin
               phase_in = PH_PRES_LOW;
               time_in  = '0;
            end
            PH_PRES_LOW, PH_PRES_HIGH: begin
               if (line_level == (phase_in == PH_PRES_HIGH)) begin
                  if (phase_in == PH_PRES_LOW) begin
                     phase_in = PH_PRES_HIGH;
                  end else begin
                     time_in = '0;
                     if (cfg.presence_hold == '0) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        phase_in = PH_PRES_HOLD;
                     end
                  end
               end else if (time_in >= PRESENCE_TIMEOUT_US) begin
                  absent_in = 1'b1;
                  phase_in  = PH_IDLE;
                  time_in   = '0;
                  done      = 1'b1;
               end
            end
            PH_PRES_HOLD: begin
               if (time_in >= widen(cfg.presence_hold)) begin
                  phase_in = PH_IDLE;
                  time_in  = '0;
                  done     = 1'b1;
               end
            end
            PH_WR_LOW, PH_WR_HIGH: begin
               lim = widen(shift_in[0] ? cfg.wr1_high : cfg.wr0_high);
               if (phase_in == PH_WR_LOW) begin
                  drive = 1'b1;
                  if (time_in >= at_least_one(shift_in[0] ? cfg.wr1_low : cfg.wr0_low))
                  begin
                     time_in = '0;
                     if (lim != '0) phase_in = PH_WR_HIGH;
                  end
               end
               if ((phase_in == PH_WR_LOW && time_in == '0 && lim == '0) ||
                   (phase_in == PH_WR_HIGH && time_in != '0 && time_in >= lim)) begin
                  shift_in = shift_in >> 1;
                  time_in  = '0;
                  if (bit_idx_in == 3'd7) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_idx_in = bit_idx_in + 3'd1;
                     phase_in   = PH_WR_LOW;
                  end
               end
            end
            PH_RD_LOW: begin
               drive = 1'b1;
               if (time_in >= at_least_one(cfg.rd_low)) begin
                  phase_in = PH_RD_REL;
                  time_in  = '0;
               end
            end
            PH_RD_REL, PH_RD_REC: begin
               if (phase_in == PH_RD_REL) begin
                  shift_in = {line_level, shift_in[BYTE_W-1:1]};
                  time_in  = '0;
                  if (cfg.rd_recovery != '0) phase_in = PH_RD_REC;
               end
               if ((phase_in == PH_RD_REL) ||
                   (phase_in == PH_RD_REC && time_in != '0 &&
                    time_in >= widen(cfg.rd_recovery))) begin
                  time_in = '0;
                  if (bit_idx_in == 3'd7) begin
                     rx_in    = shift_in;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     bit_idx_in = bit_idx_in + 3'd1;
                     phase_in   = PH_RD_LOW;
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               time_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         time_ff    <= '0;
         bit_idx_ff <= '0;
         shift_ff   <= '0;
         rx_ff      <= '0;
         absent_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         time_ff    <= time_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         rx_ff      <= rx_in;
         absent_ff  <= absent_in;
      end
   end

   assign result.drive_low = drive;
   assign result.busy      = busy;
   assign result.done      = done;
   assign result.rx_byte   = rx_in;
   assign result.no_device = absent_in;

endmodule
`default_nettype wire

/* dv/one_wire_bus_master_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_test
// Self-checking bench for the 1-Wire bus master core.
//
// A queue of microsecond tick transfers feeds a bursty driver. Each accepted
// tick also steps a local timing model of the master, which queues the result
// that tick must produce. A monitor with its own stall pattern compares every
// result transfer, field by field, against the oldest queued prediction.
// The run starts with a directed read at the reset timing. It then covers
// all-zero timing, including a presence timeout, and ends with randomly
// timed phases of mostly well-formed reset, write and read sequences.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core_test;
   import owbm_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 50;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RST_LOW, ST_RST_REL, ST_PRES_LOW, ST_PRES_HIGH, ST_PRES_HOLD,
      ST_WR_LOW, ST_WR_HIGH, ST_RD_LOW, ST_RD_REL, ST_RD_REC
   } bus_phase_type;

   typedef enum int {PRES_NORMAL, PRES_ABSENT, PRES_STUCK, PRES_NOISE} pres_style_type;

   typedef struct {
      req_code_type kind;
      logic [7:0]   tx;
      logic         line;
   } tick_item_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = REQ_TICK;
   logic [BYTE_W-1:0] req_tx_byte = '0;
   logic              req_line_level = 1'b1;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_drive_low;
   logic              rsp_busy_res;
   logic              rsp_done_res;
   logic [BYTE_W-1:0] rsp_rx_byte;
   logic              rsp_no_device;
   logic              csr_wr_en = 1'b0;
   cfg_index_type     csr_index = CFG_RESET_LOW;
   cfg_word_type      csr_wr_data = '0;

   one_wire_bus_master_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_tx_byte    (req_tx_byte),
      .req_line_level (req_line_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_drive_low  (rsp_drive_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_no_device  (rsp_no_device),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #6 clock = ~clock;

   // timing model state
   cfg_word_type      reg_val [CFG_NUM];
   cfg_word_type      next_regs [CFG_NUM];
   bus_phase_type     bus_phase = ST_IDLE;
   logic [TIME_W-1:0] tick_count = '0;
   logic [2:0]        bit_pos = '0;
   logic [7:0]        shift_reg = '0;
   logic [7:0]        read_byte = '0;
   logic              absent_seen = 1'b0;
   logic              done_flag = 1'b0;

   tick_item_type     tick_feed_q[$];
   step_result_type   expect_q[$];
   tick_item_type     drv_item;
   step_result_type   want;
   int                burst_left = 0;
   int                gap_left = 0;
   int                stall_mode = 0;
   int                stall_span = 0;
   int                cycle_count = 0;
   int                mismatch_count = 0;
   int                phase_items = 0;
   bit                hold_feed = 1'b0;

   function automatic logic [TIME_W-1:0] at_least_one_us(cfg_word_type v);
      return (v == '0) ? 11'd1 : {1'b0, v};
   endfunction

   task automatic finish_command();
      bus_phase  = ST_IDLE;
      tick_count = '0;
      done_flag  = 1'b1;
   endtask

   task automatic next_write_bit();
      shift_reg  = shift_reg >> 1;
      tick_count = '0;
      if (bit_pos == 3'd7) begin
         finish_command();
      end else begin
         bit_pos++;
         bus_phase = ST_WR_LOW;
      end
   endtask

   task automatic next_read_bit();
      tick_count = '0;
      if (bit_pos == 3'd7) begin
         read_byte = shift_reg;
         finish_command();
      end else begin
         bit_pos++;
         bus_phase = ST_RD_LOW;
      end
   endtask

   task automatic step_bus_model(input logic [1:0] kind, input logic [7:0] tx,
                                 input logic line);
      step_result_type res;
      logic [TIME_W-1:0] lim;
      logic drive;
      logic busy;
      drive = 1'b0;
      busy = 1'b0;
      done_flag = 1'b0;
      if (bus_phase == ST_IDLE && kind != REQ_TICK) begin
         tick_count = '0;
         bit_pos = '0;
         case (kind)
            REQ_RESET: begin
               absent_seen = 1'b0;
               bus_phase = ST_RST_LOW;
            end
            REQ_WRITE: begin
               shift_reg = tx;
               bus_phase = ST_WR_LOW;
            end
            default: begin
               shift_reg = '0;
               bus_phase = ST_RD_LOW;
            end
         endcase
      end
      if (bus_phase != ST_IDLE) begin
         busy = 1'b1;
         if (tick_count < TIME_MAX) tick_count++;
         case (bus_phase)
            ST_RST_LOW: begin
               drive = 1'b1;
               if (tick_count >= at_least_one_us(reg_val[CFG_RESET_LOW])) begin
                  bus_phase = ST_RST_REL;
                  tick_count = '0;
               end
            end
            ST_RST_REL: begin
               bus_phase = ST_PRES_LOW;
               tick_count = '0;
            end
            ST_PRES_LOW: begin
               if (!line) begin
                  bus_phase = ST_PRES_HIGH;
               end else if (tick_count >= PRESENCE_TIMEOUT_US) begin
                  absent_seen = 1'b1;
                  finish_command();
               end
            end
            ST_PRES_HIGH: begin
               if (line) begin
                  tick_count = '0;
                  if (reg_val[CFG_PRESENCE_HOLD] == '0) finish_command();
                  else bus_phase = ST_PRES_HOLD;
               end else if (tick_count >= PRESENCE_TIMEOUT_US) begin
                  absent_seen = 1'b1;
                  finish_command();
               end
            end
            ST_PRES_HOLD: begin
               if (tick_count >= reg_val[CFG_PRESENCE_HOLD]) finish_command();
            end
            ST_WR_LOW: begin
               drive = 1'b1;
               lim = at_least_one_us(shift_reg[0] ? reg_val[CFG_WR1_LOW] :
                                                    reg_val[CFG_WR0_LOW]);
               if (tick_count >= lim) begin
                  lim = TIME_W'(shift_reg[0] ? reg_val[CFG_WR1_HIGH] :
                                               reg_val[CFG_WR0_HIGH]);
                  tick_count = '0;
                  if (lim == '0) next_write_bit();
                  else bus_phase = ST_WR_HIGH;
               end
            end
            ST_WR_HIGH: begin
               lim = TIME_W'(shift_reg[0] ? reg_val[CFG_WR1_HIGH] :
                                            reg_val[CFG_WR0_HIGH]);
               if (tick_count >= lim) next_write_bit();
            end
            ST_RD_LOW: begin
               drive = 1'b1;
               if (tick_count >= at_least_one_us(reg_val[CFG_RD_LOW])) begin
                  bus_phase = ST_RD_REL;
                  tick_count = '0;
               end
            end
            ST_RD_REL: begin
               shift_reg = {line, shift_reg[7:1]};
               tick_count = '0;
               if (reg_val[CFG_RD_RECOVERY] == '0) next_read_bit();
               else bus_phase = ST_RD_REC;
            end
            ST_RD_REC: begin
               if (tick_count >= reg_val[CFG_RD_RECOVERY]) next_read_bit();
            end
            default: begin
               bus_phase = ST_IDLE;
               tick_count = '0;
            end
         endcase
      end
      res.drive_low = drive;
      res.busy      = busy;
      res.done      = done_flag;
      res.rx_byte   = read_byte;
      res.no_device = absent_seen;
      expect_q.push_back(res);
   endtask

   // driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) step_bus_model(req_type, req_tx_byte, req_line_level);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (hold_feed || tick_feed_q.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               drv_item = tick_feed_q.pop_front();
               req_valid      <= 1'b1;
               req_type       <= drv_item.kind;
               req_tx_byte    <= drv_item.tx;
               req_line_level <= drv_item.line;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   task automatic report_diff(input string field, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, field, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // monitor: check each result transfer, stall on a shifting pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expect_q.size() == 0) begin
               $display("%0t: result transfer with no prediction pending", $time);
               mismatch_count++;
            end else begin
               want = expect_q.pop_front();
               report_diff("drive_low", want.drive_low, rsp_drive_low);
               report_diff("busy_res", want.busy, rsp_busy_res);
               report_diff("done_res", want.done, rsp_done_res);
               report_diff("rx_byte", want.rx_byte, rsp_rx_byte);
               report_diff("no_device", want.no_device, rsp_no_device);
            end
         end
         if (stall_span == 0) begin
            stall_span = $urandom_range(20, 150);
            stall_mode = $urandom_range(0, 3);
         end else begin
            stall_span--;
         end
         case (stall_mode)
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            3: rsp_stall <= ((cycle_count % 5) < 2);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic queue_tick(input req_code_type kind, input logic [7:0] tx,
                             input logic line);
      tick_item_type t;
      t.kind = kind;
      t.tx   = tx;
      t.line = line;
      tick_feed_q.push_back(t);
      phase_items++;
   endtask

   // mostly plain ticks, now and then a request that lands while busy
   function automatic req_code_type follow_kind(input int i, input int n);
      if (i < n / 2 && $urandom_range(0, 15) == 0) return req_code_type'($urandom_range(1, 3));
      return REQ_TICK;
   endfunction

   task automatic queue_reset_cmd(input pres_style_type style);
      int low_end;
      int pre;
      int low_len;
      int n;
      logic line;
      low_end = int'(at_least_one_us(reg_val[CFG_RESET_LOW])) + 1;
      pre = low_end + $urandom_range(0, 6);
      low_len = $urandom_range(1, 12);
      n = pre + low_len + int'(reg_val[CFG_PRESENCE_HOLD]) + 1 + $urandom_range(0, 3);
      if (style == PRES_ABSENT || style == PRES_STUCK) begin
         pre = low_end;
         n = low_end + int'(PRESENCE_TIMEOUT_US) + $urandom_range(0, 3);
      end
      for (int i = 0; i < n; i++) begin
         case (style)
            PRES_ABSENT: line = 1'b1;
            PRES_STUCK:  line = (i < pre);
            PRES_NOISE:  line = 1'($urandom_range(0, 1));
            default:     line = (i < pre) || (i >= pre + low_len);
         endcase
         queue_tick((i == 0) ? REQ_RESET : follow_kind(i, n), 8'($urandom_range(0, 255)),
                    line);
      end
   endtask

   task automatic queue_write_cmd(input logic [7:0] tx);
      int n;
      n = 0;
      for (int k = 0; k < 8; k++) begin
         if (tx[k])
            n += int'(at_least_one_us(reg_val[CFG_WR1_LOW])) + int'(reg_val[CFG_WR1_HIGH]);
         else
            n += int'(at_least_one_us(reg_val[CFG_WR0_LOW])) + int'(reg_val[CFG_WR0_HIGH]);
      end
      n += $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         queue_tick((i == 0) ? REQ_WRITE : follow_kind(i, n),
                    (i == 0) ? tx : 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   task automatic queue_read_cmd();
      int n;
      n = 8 * (int'(at_least_one_us(reg_val[CFG_RD_LOW])) + 1 +
               int'(reg_val[CFG_RD_RECOVERY])) + $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         queue_tick((i == 0) ? REQ_READ : follow_kind(i, n), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
   endtask

   task automatic apply_regs();
      for (int i = 0; i < CFG_NUM; i++) begin
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_index   <= cfg_index_type'(i);
         csr_wr_data <= next_regs[i];
         reg_val[i] = next_regs[i];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      phase_items = 0;
   endtask

   task automatic wait_drained();
      while (tick_feed_q.size() != 0 || req_valid || expect_q.size() != 0)
         @(negedge clock);
   endtask

   // drain, then pad with ticks until the master is back in idle
   task automatic settle_bus();
      wait_drained();
      while (bus_phase != ST_IDLE) begin
         repeat (16) queue_tick(REQ_TICK, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)));
         wait_drained();
      end
      repeat (4) @(negedge clock);
   endtask

   function automatic cfg_word_type rand_timing();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return CFG_W'($urandom_range(0, 4));
      if (r < 9) return CFG_W'($urandom_range(5, 24));
      return CFG_W'($urandom_range(25, 60));
   endfunction

   task automatic run_random_phase(input bit with_hold);
      int pick;
      int r;
      for (int k = 0; k < CFG_NUM; k++) next_regs[k] = rand_timing();
      apply_regs();
      while (phase_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 15);
         if (pick < 5) begin
            r = $urandom_range(0, 39);
            if (r < 8) queue_reset_cmd(PRES_NOISE);
            else queue_reset_cmd(PRES_NORMAL);
         end else if (pick < 10) begin
            queue_write_cmd(8'($urandom_range(0, 255)));
         end else if (pick < 15) begin
            queue_read_cmd();
         end else begin
            repeat ($urandom_range(1, 8))
               queue_tick(req_code_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
         end
      end
      if (with_hold) begin
         while (tick_feed_q.size() > phase_items / 2) @(negedge clock);
         hold_feed = 1'b1;
         while (expect_q.size() != 0 || req_valid) @(negedge clock);
         repeat ($urandom_range(1, 20)) @(negedge clock);
         hold_feed = 1'b0;
      end
      settle_bus();
   endtask

   initial begin
      reg_val[CFG_RESET_LOW]     = CFG_RESET_VALUES.reset_low;
      reg_val[CFG_PRESENCE_HOLD] = CFG_RESET_VALUES.presence_hold;
      reg_val[CFG_WR1_LOW]       = CFG_RESET_VALUES.wr1_low;
      reg_val[CFG_WR1_HIGH]      = CFG_RESET_VALUES.wr1_high;
      reg_val[CFG_WR0_LOW]       = CFG_RESET_VALUES.wr0_low;
      reg_val[CFG_WR0_HIGH]      = CFG_RESET_VALUES.wr0_high;
      reg_val[CFG_RD_LOW]        = CFG_RESET_VALUES.rd_low;
      reg_val[CFG_RD_RECOVERY]   = CFG_RESET_VALUES.rd_recovery;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset timing: idle ticks, then a read
      queue_tick(REQ_TICK, 8'h00, 1'b1);
      queue_tick(REQ_TICK, 8'hFF, 1'b0);
      queue_read_cmd();
      settle_bus();

      // zero timing: minimum low times, skipped high, hold and recovery
      for (int k = 0; k < CFG_NUM; k++) next_regs[k] = '0;
      apply_regs();
      queue_reset_cmd(PRES_NORMAL);
      queue_write_cmd(8'hFF);
      queue_write_cmd(8'h00);
      queue_read_cmd();
      queue_reset_cmd(PRES_ABSENT);
      queue_reset_cmd(PRES_NORMAL);
      settle_bus();

      for (int p = 0; p < 3; p++) run_random_phase(p == 1);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && expect_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
